### sv/zrle_pkg.sv
`default_nettype none
package zrle_pkg;

  localparam int unsigned MAX_RUN     = 127;
  localparam int unsigned STORE_DEPTH = 127;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned LANES       = 4;
  localparam int unsigned WORD_W      = 8 * LANES;
  localparam int unsigned LANE_CNT_W  = $clog2(LANES + 1);

  localparam logic [7:0] ZERO_RUN_FLAG = 8'h80;
  localparam logic [7:0] LEN_MASK      = 8'h7f;

  // One code byte or an end-of-item flush toward the word packer.
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       flush;
    logic       last;
  } byte_req_t;

endpackage
`default_nettype wire

### sv/zrle_ram.sv
`default_nettype none
module zrle_ram (
  input  wire                          clk_i,
  input  wire                          we_i,
  input  wire [zrle_pkg::ADDR_W-1:0]   waddr_i,
  input  wire [7:0]                    wdata_i,
  input  wire [zrle_pkg::ADDR_W-1:0]   raddr_i,
  output logic [7:0]                   rdata_o
);

  logic [7:0] mem_q [zrle_pkg::STORE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### sv/zrle_pack.sv
`default_nettype none
module zrle_pack (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  zrle_pkg::byte_req_t                req_i,
  output logic                               ready_o,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic [zrle_pkg::WORD_W-1:0]        out_word_o,
  output logic [zrle_pkg::LANE_CNT_W-1:0]    out_count_o,
  output logic                               out_last_o
);

  logic [zrle_pkg::WORD_W-1:0]     acc_q, acc_d;
  logic [zrle_pkg::LANE_CNT_W-1:0] n_q, n_d;
  logic                            ov_q, ov_d;
  logic [zrle_pkg::WORD_W-1:0]     ow_q, ow_d;
  logic [zrle_pkg::LANE_CNT_W-1:0] oc_q, oc_d;
  logic                            ol_q, ol_d;
  logic                            out_free;
  logic                            byte_rdy;
  logic                            flush_rdy;
  logic [zrle_pkg::WORD_W-1:0]     byte_ext;

  assign out_free  = !ov_q || out_ready_i;
  assign byte_rdy  = (n_q != zrle_pkg::LANE_CNT_W'(zrle_pkg::LANES)) || out_free;
  assign flush_rdy = (n_q == '0) || out_free;
  assign ready_o   = req_i.flush ? flush_rdy : byte_rdy;
  assign byte_ext  = {{(zrle_pkg::WORD_W-8){1'b0}}, req_i.data};

  always_comb begin
    acc_d = acc_q;
    n_d   = n_q;
    ov_d  = ov_q;
    ow_d  = ow_q;
    oc_d  = oc_q;
    ol_d  = ol_q;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    if (req_i.vld && byte_rdy) begin
      if (n_q == zrle_pkg::LANE_CNT_W'(zrle_pkg::LANES)) begin
        // The held word is full and more bytes follow, so it is not the last.
        ov_d  = 1'b1;
        ow_d  = acc_q;
        oc_d  = n_q;
        ol_d  = 1'b0;
        acc_d = byte_ext;
        n_d   = zrle_pkg::LANE_CNT_W'(1);
      end else begin
        acc_d = acc_q | (byte_ext << {n_q[1:0], 3'b000});
        n_d   = n_q + zrle_pkg::LANE_CNT_W'(1);
      end
    end else if (req_i.flush && flush_rdy && (n_q != '0)) begin
      ov_d  = 1'b1;
      ow_d  = acc_q;
      oc_d  = n_q;
      ol_d  = req_i.last;
      acc_d = '0;
      n_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      n_q   <= '0;
      ov_q  <= 1'b0;
      ow_q  <= '0;
      oc_q  <= '0;
      ol_q  <= 1'b0;
    end else begin
      acc_q <= acc_d;
      n_q   <= n_d;
      ov_q  <= ov_d;
      ow_q  <= ow_d;
      oc_q  <= oc_d;
      ol_q  <= ol_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_word_o  = ow_q;
  assign out_count_o = oc_q;
  assign out_last_o  = ol_q;

endmodule
`default_nettype wire

### sv/zrle_ctrl.sv
`default_nettype none
module zrle_ctrl (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire [7:0]                    in_byte_i,
  input  wire                          in_last_i,
  output zrle_pkg::byte_req_t          req_o,
  input  wire                          req_ready_i,
  output logic                         we_o,
  output logic [zrle_pkg::ADDR_W-1:0]  waddr_o,
  output logic [7:0]                   wdata_o,
  output logic [zrle_pkg::ADDR_W-1:0]  raddr_o,
  input  wire [7:0]                    rdata_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TAKE  = 3'd1;
  localparam logic [2:0] S_HDR   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  localparam logic PH_PEND = 1'b0;
  localparam logic PH_LAST = 1'b1;

  logic [2:0]                   state_q, state_d;
  logic [7:0]                   pend_q, pend_d;
  logic                         have_q, have_d;
  logic                         izr_q, izr_d;
  logic [zrle_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [7:0]                   b_q, b_d;
  logic                         last_q, last_d;
  logic [7:0]                   tb_q, tb_d;
  logic                         nn_q, nn_d;
  logic                         z_q, z_d;
  logic                         final_q, final_d;
  logic                         phase_q, phase_d;
  logic [zrle_pkg::ADDR_W-1:0]  k_q, k_d;
  logic                         zero_c;
  logic                         close_c;
  logic                         close_done;

  assign zero_c  = (tb_q == 8'h00) && !(!izr_q && nn_q);
  assign close_c = (zero_c != izr_q) || (cnt_q == zrle_pkg::CNT_W'(zrle_pkg::MAX_RUN));

  always_comb begin
    state_d    = state_q;
    pend_d     = pend_q;
    have_d     = have_q;
    izr_d      = izr_q;
    cnt_d      = cnt_q;
    b_d        = b_q;
    last_d     = last_q;
    tb_d       = tb_q;
    nn_d       = nn_q;
    z_d        = z_q;
    final_d    = final_q;
    phase_d    = phase_q;
    k_d        = k_q;
    close_done = 1'b0;
    in_ready_o = 1'b0;
    req_o      = '0;
    we_o       = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          b_d    = in_byte_i;
          last_d = in_last_i;
          if (have_q) begin
            tb_d    = pend_q;
            nn_d    = (in_byte_i != 8'h00);
            phase_d = PH_PEND;
            state_d = S_TAKE;
          end else if (in_last_i) begin
            tb_d    = in_byte_i;
            nn_d    = 1'b1;
            phase_d = PH_LAST;
            state_d = S_TAKE;
          end else begin
            pend_d = in_byte_i;
            have_d = 1'b1;
          end
        end
      end
      S_TAKE: begin
        z_d     = zero_c;
        final_d = 1'b0;
        state_d = close_c ? S_HDR : S_APPLY;
      end
      S_HDR: begin
        if (izr_q) begin
          if (cnt_q == '0) begin
            close_done = 1'b1;
          end else begin
            req_o.vld  = 1'b1;
            req_o.data = zrle_pkg::ZERO_RUN_FLAG | {1'b0, cnt_q};
            close_done = req_ready_i;
          end
        end else begin
          req_o.vld  = 1'b1;
          req_o.data = {1'b0, cnt_q} & zrle_pkg::LEN_MASK;
          if (req_ready_i) begin
            if (cnt_q == '0) begin
              close_done = 1'b1;
            end else begin
              k_d     = '0;
              state_d = S_READ;
            end
          end
        end
      end
      S_READ: begin
        req_o.vld  = 1'b1;
        req_o.data = rdata_i;
        if (req_ready_i) begin
          if ((k_q + zrle_pkg::ADDR_W'(1)) == zrle_pkg::ADDR_W'(cnt_q)) begin
            close_done = 1'b1;
          end else begin
            k_d = k_q + zrle_pkg::ADDR_W'(1);
          end
        end
      end
      S_APPLY: begin
        we_o  = !z_q;
        cnt_d = cnt_q + zrle_pkg::CNT_W'(1);
        izr_d = z_q;
        if (phase_q == PH_PEND) begin
          if (last_q) begin
            tb_d    = b_q;
            nn_d    = 1'b1;
            phase_d = PH_LAST;
            state_d = S_TAKE;
          end else begin
            pend_d  = b_q;
            have_d  = 1'b1;
            state_d = S_FLUSH;
          end
        end else begin
          final_d = 1'b1;
          state_d = S_HDR;
        end
      end
      S_FLUSH: begin
        req_o.flush = 1'b1;
        req_o.last  = last_q;
        if (req_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (close_done) begin
      cnt_d = '0;
      if (final_q) begin
        izr_d   = 1'b1;
        have_d  = 1'b0;
        pend_d  = 8'h00;
        final_d = 1'b0;
        state_d = S_FLUSH;
      end else begin
        state_d = S_APPLY;
      end
    end
  end

  assign waddr_o = zrle_pkg::ADDR_W'(cnt_q);
  assign wdata_o = tb_q;
  assign raddr_o = k_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 8'h00;
      have_q  <= 1'b0;
      izr_q   <= 1'b1;
      cnt_q   <= '0;
      final_q <= 1'b0;
      phase_q <= PH_PEND;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      have_q  <= have_d;
      izr_q   <= izr_d;
      cnt_q   <= cnt_d;
      final_q <= final_d;
      phase_q <= phase_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q    <= b_d;
    last_q <= last_d;
    tb_q   <= tb_d;
    nn_q   <= nn_d;
    z_q    <= z_d;
  end

endmodule
`default_nettype wire

### sv/zero_run_length_encoder.sv
// Zero run-length encoder for a byte stream.
// Input words arrive on the s_axis channel: one raw byte in tdata, with tlast
// on the final byte of a stream. Code bytes leave on the m_axis channel packed
// up to four per word, first byte in the lowest lane; tdata also carries the
// number of valid bytes, and tlast marks the final word of the encoded stream.
// Every byte is held back one word for lookahead, so the code for a byte
// appears when the next byte, or the end of the stream, arrives.
// An input word is taken only when the encoder is idle. A word that only fills
// the empty lookahead slot is simply stored. Any other word passes through the
// accept step, a take step and an apply step per byte taken into a run, a run
// header step, a read-back of each literal byte from the 127-byte literal
// memory, and a flush of the partial output word. The memory read is registered.
// Reset returns the encoder to the start of a stream with no byte held back.
// When the receiver stalls, the output register holds its word, the packer
// holds up to four more bytes, and the sequencer then waits without loss.
`default_nettype none
module zero_run_length_encoder (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire         s_axis_tlast,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] out_word, [34:32] out_count, zero above
  output logic        m_axis_tlast
);

  zrle_pkg::byte_req_t                 req;
  logic                                req_ready;
  logic                                we;
  logic [zrle_pkg::ADDR_W-1:0]         waddr;
  logic [7:0]                          wdata;
  logic [zrle_pkg::ADDR_W-1:0]         raddr;
  logic [7:0]                          rdata;
  logic [zrle_pkg::WORD_W-1:0]         out_word;
  logic [zrle_pkg::LANE_CNT_W-1:0]     out_count;

  zrle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .req_o       (req),
    .req_ready_i (req_ready),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  zrle_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  zrle_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .ready_o     (req_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_word_o  (out_word),
    .out_count_o (out_count),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b00000, out_count, out_word};

endmodule
`default_nettype wire

### sv/zrle_chk.sv
`default_nettype none
module zrle_chk (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire [7:0]  s_axis_tdata,
  input wire        s_axis_tlast,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [39:0] m_axis_tdata,
  input wire        m_axis_tlast
);

  // A stalled output word keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // Every output word carries one to four bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[34:32] != 3'd0 && m_axis_tdata[34:32] <= 3'd4)
    else $error("output byte count out of range");

  // Byte lanes beyond the count are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[34:32] != 3'd1 || m_axis_tdata[31:8] == 24'd0) &&
      (m_axis_tdata[34:32] != 3'd2 || m_axis_tdata[31:16] == 16'd0) &&
      (m_axis_tdata[34:32] != 3'd3 || m_axis_tdata[31:24] == 8'd0))
    else $error("unused byte lane not zero");

  // The final byte of a stream always starts encoding work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("final byte taken without encoding work");

endmodule

bind zero_run_length_encoder zrle_chk u_chk (.*);
`default_nettype wire
